@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the decoder RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational property, checked at every clock edge outside reset
`define HTSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication into the next cycle, checked outside reset
`define HTSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/htsd_pkg.sv @@
// Types and constants of the Huffman tree string decoder
`default_nettype none

package htsd_pkg;

    // Command codes of an input word
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Node table markers
    localparam logic [7:0] NO_CHILD   = 8'hFF;
    localparam logic [7:0] TERMINATOR = 8'h7C;
    localparam logic [7:0] ROOT_RESET = 8'hFF;

    // Bits in one coded byte
    localparam logic [3:0] CODE_BITS = 4'd8;

    // One node table entry
    typedef struct packed {
        logic [7:0] chr;
        logic [7:0] left;
        logic [7:0] right;
    } t_node;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DESCEND,
        S_CHECK,
        S_FLUSH
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic cfg_we;
        logic wr_entry;
        logic load_byte;
        logic descend;
        logic go_root;
        logic emit;
        logic flush;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic leaf;
        logic term;
        logic bits_done;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ rtl/core/htsd_ctrl.sv @@
// Controller state machine of the Huffman tree string decoder
`default_nettype none

`include "assert_macros.svh"

module htsd_ctrl
    import htsd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire logic    i_command,
    input  wire logic    i_cfg_valid,
    input  wire t_dp_sts i_sts,
    output logic         busy,
    output logic         o_cfg_ready,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = start && !busy;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_command == CMD_DECODE)) begin
                    n_state = S_DESCEND;
                end
            end
            S_DESCEND: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.leaf) begin
                    if (i_sts.term || i_sts.bits_done) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_state = S_DESCEND;
                    end
                end else if (i_sts.bits_done) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        busy        = (r_state != S_IDLE);
        o_cfg_ready = (r_state == S_IDLE);
        o_cmd       = '0;
        o_cmd.cfg_we = i_cfg_valid && (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.wr_entry  = start && (i_command == CMD_LOAD);
                o_cmd.load_byte = start && (i_command == CMD_DECODE);
            end
            S_DESCEND: begin
                o_cmd.descend = 1'b1;
            end
            S_CHECK: begin
                if (i_sts.leaf) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.go_root = 1'b1;
                end else if (!i_sts.bits_done) begin
                    o_cmd.descend = 1'b1;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // A decode word always starts the walk with a descend step
    `HTSD_ASSERT_NEXT(a_decode_starts, w_accept && (i_command == CMD_DECODE),
        r_state == S_DESCEND, "decode word did not start a walk")
    // The block only goes idle after flushing the pending result
    `HTSD_ASSERT_NEXT(a_idle_after_flush, busy && (n_state == S_IDLE),
        $past(r_state) == S_FLUSH, "walk ended without a flush")
    // A leaf step always returns the walk to the root
    `HTSD_ASSERT(a_leaf_goes_root, !o_cmd.emit || o_cmd.go_root,
        "leaf emitted without returning to root")

endmodule

`default_nettype wire

@@ rtl/core/htsd_datapath.sv @@
// Datapath of the Huffman tree string decoder: node table, walk and result registers
`default_nettype none

`include "assert_macros.svh"

module htsd_datapath
    import htsd_pkg::*;
#(
    parameter int NODE_DEPTH = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_sts         o_sts,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic [7:0] i_node_index,
    input  wire logic [7:0] i_node_char,
    input  wire logic [7:0] i_node_left,
    input  wire logic [7:0] i_node_right,
    input  wire logic [7:0] i_code_byte,
    output logic            o_result_valid,
    output logic [7:0]      o_character,
    output logic            o_end_of_string,
    output logic            o_last_of_item
);

    localparam int         AW        = $clog2(NODE_DEPTH);
    localparam logic [8:0] IDX_LIMIT = 9'(NODE_DEPTH);

    // Node table
    t_node      mem [NODE_DEPTH];
    t_node      r_rd_q;
    logic       r_rd_oob;

    // Walk state
    logic [7:0] r_root;
    logic [7:0] r_cur;
    logic       r_at_root;
    logic [7:0] r_code;
    logic [3:0] r_bits_left;

    // Held result, emitted once the next leaf or the end of the byte is known
    logic       r_pend_vld;
    logic [7:0] r_pend_chr;
    logic       r_pend_eos;

    // Result registers
    logic       r_out_vld;
    logic [7:0] r_out_chr;
    logic       r_out_eos;
    logic       r_out_last;

    t_node      w_ent;
    logic [7:0] w_child;
    logic [7:0] w_rd_idx;
    logic       w_rd_en;
    logic       w_leaf;
    logic       w_term;

    // Entry just read; an index beyond the table reads as all zeros
    assign w_ent   = r_rd_oob ? '0 : r_rd_q;
    assign w_child = r_code[7] ? w_ent.right : w_ent.left;
    assign w_leaf  = (w_ent.left == NO_CHILD) && (w_ent.right == NO_CHILD);
    assign w_term  = (w_ent.chr == TERMINATOR);

    assign o_sts.leaf      = w_leaf;
    assign o_sts.term      = w_term;
    assign o_sts.bits_done = (r_bits_left == 4'd0);

    // Read address select
    always_comb begin
        w_rd_en  = 1'b1;
        w_rd_idx = r_root;
        if (i_cmd.load_byte) begin
            w_rd_idx = r_at_root ? r_root : r_cur;
        end else if (i_cmd.descend) begin
            w_rd_idx = w_child;
        end else if (i_cmd.go_root) begin
            w_rd_idx = r_root;
        end else begin
            w_rd_en = 1'b0;
        end
    end

    // Table write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry && ({1'b0, i_node_index} < IDX_LIMIT)) begin
            mem[i_node_index[AW-1:0]] <= '{chr: i_node_char, left: i_node_left,
                                           right: i_node_right};
        end
    end

    // Table read port, registered
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_q   <= mem[w_rd_idx[AW-1:0]];
            r_rd_oob <= !({1'b0, w_rd_idx} < IDX_LIMIT);
        end
    end

    // Root register and walk position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root    <= ROOT_RESET;
            r_cur     <= 8'd0;
            r_at_root <= 1'b1;
        end else begin
            if (i_cmd.cfg_we) begin
                r_root <= i_cfg_data;
            end
            if (i_cmd.descend) begin
                r_cur     <= w_child;
                r_at_root <= 1'b0;
            end else if (i_cmd.go_root) begin
                r_cur     <= r_root;
                r_at_root <= 1'b1;
            end
        end
    end

    // Code byte shifter, MSB is the bit in use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_left <= 4'd0;
        end else if (i_cmd.load_byte) begin
            r_bits_left <= CODE_BITS;
        end else if (i_cmd.descend) begin
            r_bits_left <= r_bits_left - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_code <= i_code_byte;
        end else if (i_cmd.descend) begin
            r_code <= {r_code[6:0], 1'b0};
        end
    end

    // Held result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_pend_vld <= 1'b1;
        end else if (i_cmd.flush) begin
            r_pend_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pend_chr <= w_ent.chr;
            r_pend_eos <= w_term;
        end
    end

    // Result strobe: older held word on a new leaf, final word on flush
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= (i_cmd.emit || i_cmd.flush) && r_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_chr  <= r_pend_chr;
        r_out_eos  <= r_pend_eos;
        r_out_last <= i_cmd.flush;
    end

    assign o_result_valid  = r_out_vld;
    assign o_character     = r_out_chr;
    assign o_end_of_string = r_out_eos;
    assign o_last_of_item  = r_out_last;

    // The final word of a byte leaves nothing held behind
    `HTSD_ASSERT(a_last_clears_pend, !(r_out_vld && r_out_last) || !r_pend_vld,
        "held result left after final word")
    // A terminator is always the final word of its byte
    `HTSD_ASSERT(a_eos_is_last, !(r_out_vld && r_out_eos) || r_out_last,
        "terminator not marked as final word")

endmodule

`default_nettype wire

@@ rtl/core/huffman_tree_string_decoder.sv @@
// Top level of the Huffman tree string decoder
//
// Channel   Direction  Handshake                       Payload
// command   in         start & !busy                   i_command, i_node_*, i_code_byte
// config    in         i_cfg_valid & o_cfg_ready       i_cfg_data (root_index)
// result    out        o_result_valid, one cycle       o_character, o_end_of_string,
//                                                      o_last_of_item
//
// A load word writes one table entry in its accept cycle and keeps busy low.
// A decode word holds busy high for its walk: one table read per bit and one more to
// refetch the root after each leaf found before the last bit that does not end the
// string; a terminator ends the walk at its own bit.
// Each result is held until the next leaf or the end of the byte, then strobed;
// the last one comes in the cycle in which busy falls.
// Reset is synchronous and active low; the node table is not cleared.
// The result side cannot stall; configuration is taken only while busy is low.
`default_nettype none

module huffman_tree_string_decoder
    import htsd_pkg::*;
#(
    parameter int NODE_DEPTH = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       i_command,
    input  wire logic [7:0] i_node_index,
    input  wire logic [7:0] i_node_char,
    input  wire logic [7:0] i_node_left,
    input  wire logic [7:0] i_node_right,
    input  wire logic [7:0] i_code_byte,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data,
    output logic            o_result_valid,
    output logic [7:0]      o_character,
    output logic            o_end_of_string,
    output logic            o_last_of_item
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Controller
    htsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_command   (i_command),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (w_sts),
        .busy        (busy),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    // Datapath
    htsd_datapath #(
        .NODE_DEPTH (NODE_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_data      (i_cfg_data),
        .i_node_index    (i_node_index),
        .i_node_char     (i_node_char),
        .i_node_left     (i_node_left),
        .i_node_right    (i_node_right),
        .i_code_byte     (i_code_byte),
        .o_result_valid  (o_result_valid),
        .o_character     (o_character),
        .o_end_of_string (o_end_of_string),
        .o_last_of_item  (o_last_of_item)
    );

endmodule

`default_nettype wire
